// File: rtl/core/cig_pkg.sv
// ----------------------------------------------------------------------------
// cig_pkg
// Shared widths, angle constants, CORDIC cell record and arctangent table
// for the circle increment generator.
// ----------------------------------------------------------------------------
package cig_pkg;

    localparam int CORDIC_STAGES_DEF = 24;
    localparam int CORDIC_STAGES_MAX = 30;

    localparam int W_CFG  = 32;
    localparam int W_ADDR = 2;
    localparam int W_XY   = 32;
    localparam int W_Z    = 33;
    localparam int W_OP   = 33;
    localparam int W_PROD = 2 * W_OP;

    localparam logic [W_ADDR-1:0] REG_RADIUS   = 2'd0;
    localparam logic [W_ADDR-1:0] REG_RATE     = 2'd1;
    localparam logic [W_ADDR-1:0] REG_PERIOD   = 2'd2;
    localparam logic [W_ADDR-1:0] REG_FREE_RUN = 2'd3;

    // Q3.29 angles
    localparam logic [31:0] TWO_PI_Q29        = 32'd3373259426;
    localparam logic [31:0] PI_Q29            = 32'd1686629713;
    localparam logic [31:0] HALF_PI_Q29       = 32'd843314856;
    localparam logic [31:0] THREE_HALF_PI_Q29 = 32'd2529944570;

    // 1/K in Q1.30
    localparam logic signed [W_XY-1:0] CORDIC_GAIN_Q30 = 32'sd652032874;

    typedef struct packed {
        logic                   vld;
        logic signed [W_XY-1:0] x;
        logic signed [W_XY-1:0] y;
        logic signed [W_Z-1:0]  z;
    } t_cordic;

    function automatic logic [31:0] atan_q30(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'd843314856;
            1:  v = 32'd497837829;
            2:  v = 32'd263043836;
            3:  v = 32'd133525158;
            4:  v = 32'd67021686;
            5:  v = 32'd33543515;
            6:  v = 32'd16775850;
            7:  v = 32'd8388437;
            8:  v = 32'd4194282;
            9:  v = 32'd2097149;
            10: v = 32'd1048576;
            11: v = 32'd524288;
            12: v = 32'd262144;
            13: v = 32'd131072;
            14: v = 32'd65536;
            15: v = 32'd32768;
            16: v = 32'd16384;
            17: v = 32'd8192;
            18: v = 32'd4096;
            19: v = 32'd2048;
            20: v = 32'd1024;
            21: v = 32'd512;
            22: v = 32'd256;
            23: v = 32'd128;
            24: v = 32'd64;
            25: v = 32'd32;
            26: v = 32'd16;
            27: v = 32'd8;
            28: v = 32'd4;
            29: v = 32'd2;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/core/cig_cordic_cell.sv
// ----------------------------------------------------------------------------
// cig_cordic_cell
// One rotation-mode CORDIC micro-rotation with its own output register.
// ----------------------------------------------------------------------------
module cig_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cig_pkg::t_cordic i_cell,
    output cig_pkg::t_cordic o_cell
);

    localparam logic signed [cig_pkg::W_Z-1:0] ATAN =
        $signed({1'b0, cig_pkg::atan_q30(IDX)});

    logic                            r_vld;
    logic signed [cig_pkg::W_XY-1:0] r_x;
    logic signed [cig_pkg::W_XY-1:0] r_y;
    logic signed [cig_pkg::W_Z-1:0]  r_z;
    logic signed [cig_pkg::W_XY-1:0] n_x;
    logic signed [cig_pkg::W_XY-1:0] n_y;
    logic signed [cig_pkg::W_Z-1:0]  n_z;
    logic signed [cig_pkg::W_XY-1:0] xs;
    logic signed [cig_pkg::W_XY-1:0] ys;

    always_comb begin
        xs = i_cell.x >>> IDX;
        ys = i_cell.y >>> IDX;
        if (!i_cell.z[cig_pkg::W_Z-1]) begin
            n_x = i_cell.x - ys;
            n_y = i_cell.y + xs;
            n_z = i_cell.z - ATAN;
        end else begin
            n_x = i_cell.x + ys;
            n_y = i_cell.y - xs;
            n_z = i_cell.z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_cell.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_cell.vld = r_vld;
    assign o_cell.x   = r_x;
    assign o_cell.y   = r_y;
    assign o_cell.z   = r_z;

endmodule

// File: rtl/core/cig_mul.sv
// ----------------------------------------------------------------------------
// cig_mul
// Shared signed multiplier with a registered product; holds when disabled.
// ----------------------------------------------------------------------------
module cig_mul (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [cig_pkg::W_OP-1:0]   i_a,
    input  logic signed [cig_pkg::W_OP-1:0]   i_b,
    output logic signed [cig_pkg::W_PROD-1:0] o_p
);

    logic signed [cig_pkg::W_PROD-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_a * i_b;
        end
    end

    assign o_p = r_p;

endmodule

// File: rtl/core/circle_increment_generator.sv
// ----------------------------------------------------------------------------
// circle_increment_generator
// Per-frame circular interpolator: angle step, wrapped phase accumulator,
// chain of CORDIC cells, scaled and saturated x/y increments.
//
//   channel | dir | tdata                                  | tuser
//   s_axis  | in  | [31:0] input_increment                 | -
//   m_axis  | out | [31:0] delta_x, [63:32] delta_y        | [0] saturated
//   cfg     | in  | 0 radius, 1 angular_rate, 2 frame_period, 3 free_run
//
// From accept to result an item makes five passes through the one shared
// multiplier and goes through the step, phase and fold states, each cell of
// the CORDIC chain and a final state that loads the output register.
// A new item is taken only after the result enters the output register, so
// one item is in flight at a time; a stalled output holds the result there
// and the next one waits in the final state. Reset is synchronous and clears
// the control state, phase, configuration and valid flags.
// ----------------------------------------------------------------------------
module circle_increment_generator #(
    parameter int CORDIC_STAGES = cig_pkg::CORDIC_STAGES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [31:0]                  i_s_tdata,   // [31:0] input_increment
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [63:0]                  o_m_tdata,   // [31:0] delta_x, [63:32] delta_y
    output logic                         o_m_tuser,   // [0] saturated
    input  logic                         i_cfg_we,
    input  logic [cig_pkg::W_ADDR-1:0]   i_cfg_addr,
    input  logic [cig_pkg::W_CFG-1:0]    i_cfg_wdata
);

    localparam int WO = cig_pkg::W_OP;
    localparam int WP = cig_pkg::W_PROD;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MSTEP  = 4'd1;
    localparam logic [3:0] S_STEP   = 4'd2;
    localparam logic [3:0] S_PHASE  = 4'd3;
    localparam logic [3:0] S_FOLD   = 4'd4;
    localparam logic [3:0] S_CORDIC = 4'd5;
    localparam logic [3:0] S_MX     = 4'd6;
    localparam logic [3:0] S_MY     = 4'd7;
    localparam logic [3:0] S_RX     = 4'd8;
    localparam logic [3:0] S_RY     = 4'd9;
    localparam logic [3:0] S_FIN    = 4'd10;

    localparam logic signed [WP-1:0] RND_IN  = WP'(1024);
    localparam logic signed [WP-1:0] RND_FR  = WP'(67108864);
    localparam logic signed [WP-1:0] RND_T   = WP'(536870912);
    localparam logic signed [WP-1:0] STEP_HI =
        $signed({34'd0, cig_pkg::TWO_PI_Q29 - 32'd1});
    localparam logic signed [WP-1:0] STEP_LO = -STEP_HI;
    localparam logic signed [WO-1:0] STEP_MAX =
        $signed({1'b0, cig_pkg::TWO_PI_Q29 - 32'd1});
    localparam logic signed [33:0] TP34 = $signed({2'b00, cig_pkg::TWO_PI_Q29});

    function automatic logic [32:0] scale_out(input logic [WP-1:0] prod,
                                              input logic neg, input logic ovf);
        logic [64:0] sum;
        logic [35:0] r;
        logic        sat;
        logic [31:0] v;
        sum = {1'b0, prod[63:0]} + 65'd268435456;
        r   = sum[64:29];
        sat = 1'b0;
        if (neg) begin
            if (ovf || r > 36'h080000000) begin
                sat = 1'b1;
                v   = 32'h80000000;
            end else begin
                v = 32'(-r);
            end
        end else begin
            if (ovf || r > 36'h07FFFFFFF) begin
                sat = 1'b1;
                v   = 32'h7FFFFFFF;
            end else begin
                v = r[31:0];
            end
        end
        return {sat, v};
    endfunction

    logic [3:0]              r_state;
    logic                    r_run;
    logic [31:0]             r_radius;
    logic [31:0]             r_rate;
    logic [31:0]             r_period;
    logic                    r_free;
    logic [31:0]             r_phase;
    logic [31:0]             r_inc;
    logic signed [WO-1:0]    r_step;
    logic                    r_sat;
    logic                    r_neg;
    logic signed [31:0]      r_cx;
    logic signed [31:0]      r_cy;
    logic                    r_tx_neg;
    logic                    r_tx_ovf;
    logic [31:0]             r_tx_mag;
    logic                    r_ty_neg;
    logic                    r_ty_ovf;
    logic [31:0]             r_ty_mag;
    logic [31:0]             r_dx;
    logic                    r_out_valid;
    logic [31:0]             r_out_dx;
    logic [31:0]             r_out_dy;
    logic                    r_out_sat;

    logic                    s_acc;
    logic                    m_acc;
    logic                    mul_en;
    logic signed [WO-1:0]    mul_a;
    logic signed [WO-1:0]    mul_b;
    logic signed [WP-1:0]    prod;
    logic signed [WP-1:0]    s_sum;
    logic signed [WP-1:0]    s_shf;
    logic signed [WO-1:0]    n_step;
    logic                    n_step_sat;
    logic signed [33:0]      p_sum;
    logic signed [33:0]      p_wrap;
    logic signed [33:0]      fold_a;
    logic                    fold_neg;
    logic signed [WP-1:0]    t_full;
    logic signed [WP-1:0]    t_mag;
    logic [32:0]             sc_x;
    logic [32:0]             sc_y;
    logic                    fin_go;

    cig_pkg::t_cordic        c_chain [CORDIC_STAGES+1];

    assign s_acc      = i_s_tvalid && o_s_tready;
    assign m_acc      = r_out_valid && i_m_tready;
    assign o_s_tready = r_run && (r_state == S_IDLE);
    assign fin_go     = (r_state == S_FIN) && (!r_out_valid || i_m_tready);

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= '0;
            r_rate   <= '0;
            r_period <= '0;
            r_free   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                cig_pkg::REG_RADIUS:   r_radius <= i_cfg_wdata;
                cig_pkg::REG_RATE:     r_rate   <= i_cfg_wdata;
                cig_pkg::REG_PERIOD:   r_period <= i_cfg_wdata;
                cig_pkg::REG_FREE_RUN: r_free   <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (r_state)
            S_MSTEP: begin
                mul_a = $signed({r_rate[31], r_rate});
                mul_b = r_free ? $signed({1'b0, r_period}) : $signed({r_inc[31], r_inc});
            end
            S_MX: begin
                mul_a = r_step;
                mul_b = $signed({r_cx[31], r_cx});
            end
            S_MY: begin
                mul_a = r_step;
                mul_b = $signed({r_cy[31], r_cy});
            end
            S_RX: begin
                mul_a = $signed({1'b0, r_radius});
                mul_b = $signed({1'b0, r_tx_mag});
            end
            S_RY: begin
                mul_a = $signed({1'b0, r_radius});
                mul_b = $signed({1'b0, r_ty_mag});
            end
            default: mul_en = 1'b0;
        endcase
    end

    cig_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    // angle step with clamp
    always_comb begin
        s_sum      = prod + (r_free ? RND_FR : RND_IN);
        s_shf      = r_free ? (s_sum >>> 27) : (s_sum >>> 11);
        n_step_sat = 1'b0;
        if (s_shf > STEP_HI) begin
            n_step     = STEP_MAX;
            n_step_sat = 1'b1;
        end else if (s_shf < STEP_LO) begin
            n_step     = -STEP_MAX;
            n_step_sat = 1'b1;
        end else begin
            n_step = s_shf[WO-1:0];
        end
    end

    // phase wrap in both directions
    always_comb begin
        p_sum = $signed({2'b00, r_phase}) + $signed({r_step[WO-1], r_step});
        if (p_sum >= TP34) begin
            p_wrap = p_sum - TP34;
        end else if (p_sum < 34'sd0) begin
            p_wrap = p_sum + TP34;
        end else begin
            p_wrap = p_sum;
        end
    end

    // fold phase into [-pi/2, pi/2)
    always_comb begin
        fold_neg = 1'b0;
        if (r_phase < cig_pkg::HALF_PI_Q29) begin
            fold_a = $signed({2'b00, r_phase});
        end else if (r_phase < cig_pkg::THREE_HALF_PI_Q29) begin
            fold_a   = $signed({2'b00, r_phase}) - $signed({2'b00, cig_pkg::PI_Q29});
            fold_neg = 1'b1;
        end else begin
            fold_a = $signed({2'b00, r_phase}) - TP34;
        end
    end

    assign c_chain[0].vld = (r_state == S_FOLD);
    assign c_chain[0].x   = cig_pkg::CORDIC_GAIN_Q30;
    assign c_chain[0].y   = '0;
    assign c_chain[0].z   = $signed({fold_a[31:0], 1'b0});

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        cig_cordic_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cell  (c_chain[g]),
            .o_cell  (c_chain[g+1])
        );
    end

    // rounded Q3.29 product and its magnitude
    always_comb begin
        t_full = (prod + RND_T) >>> 30;
        t_mag  = t_full[WP-1] ? -t_full : t_full;
    end

    assign sc_x = scale_out(prod, r_tx_neg, r_tx_ovf);
    assign sc_y = scale_out(prod, r_ty_neg, r_ty_ovf);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_run   <= 1'b0;
            r_phase <= '0;
        end else begin
            r_run <= 1'b1;
            case (r_state)
                S_IDLE:   if (s_acc) r_state <= S_MSTEP;
                S_MSTEP:  r_state <= S_STEP;
                S_STEP:   r_state <= S_PHASE;
                S_PHASE: begin
                    r_phase <= p_wrap[31:0];
                    r_state <= S_FOLD;
                end
                S_FOLD:   r_state <= S_CORDIC;
                S_CORDIC: if (c_chain[CORDIC_STAGES].vld) r_state <= S_MX;
                S_MX:     r_state <= S_MY;
                S_MY:     r_state <= S_RX;
                S_RX:     r_state <= S_RY;
                S_RY:     r_state <= S_FIN;
                S_FIN:    if (fin_go) r_state <= S_IDLE;
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_inc <= i_s_tdata;
        end
        if (r_state == S_STEP) begin
            r_step <= n_step;
            r_sat  <= n_step_sat;
        end
        if (r_state == S_FOLD) begin
            r_neg <= fold_neg;
        end
        if (r_state == S_CORDIC && c_chain[CORDIC_STAGES].vld) begin
            r_cx <= r_neg ? -c_chain[CORDIC_STAGES].x : c_chain[CORDIC_STAGES].x;
            r_cy <= r_neg ? -c_chain[CORDIC_STAGES].y : c_chain[CORDIC_STAGES].y;
        end
        if (r_state == S_MY) begin
            r_tx_neg <= t_full[WP-1];
            r_tx_ovf <= |t_mag[WP-1:32];
            r_tx_mag <= t_mag[31:0];
        end
        if (r_state == S_RX) begin
            r_ty_neg <= t_full[WP-1];
            r_ty_ovf <= |t_mag[WP-1:32];
            r_ty_mag <= t_mag[31:0];
        end
        if (r_state == S_RY) begin
            r_dx  <= sc_x[31:0];
            r_sat <= r_sat | sc_x[32];
        end
        if (fin_go) begin
            r_out_dx  <= r_dx;
            r_out_dy  <= sc_y[31:0];
            r_out_sat <= r_sat | sc_y[32];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin_go) begin
            r_out_valid <= 1'b1;
        end else if (m_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_dy, r_out_dx};
    assign o_m_tuser  = r_out_sat;

endmodule

// File: rtl/core/cig_checker.sv
// ----------------------------------------------------------------------------
// cig_checker
// Port-level checks on reset, item flow and output hold, bound to the top.
// ----------------------------------------------------------------------------
module cig_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [63:0] o_m_tdata,
    input logic        o_m_tuser
);

    logic s_acc;

    assign s_acc = i_s_tvalid && o_s_tready;

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_s_tready && !o_m_tvalid))
        else $error("ports not quiet after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("stalled output item changed");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !o_s_tready)
        else $error("second item taken while busy");

    a_no_bypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> !$past(s_acc))
        else $error("result appeared one cycle after accept");

endmodule

bind circle_increment_generator cig_checker u_cig_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

// File: dv/circle_increment_generator_tb.sv
// ----------------------------------------------------------------------------
// circle_increment_generator_tb
// Self-checking bench for the circle increment generator. An in-bench
// predictor tracks the phase and forms the expected x/y increments and
// saturation flag for every item. A queue of pending items feeds a stream
// driver, and a monitor compares each result in order against the
// expectation queue. The run covers directed corner cases, random register
// settings and items, and phases of sender and receiver idling.
// ----------------------------------------------------------------------------
module circle_increment_generator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CORDIC_STAGES = cig_pkg::CORDIC_STAGES_DEF;

    localparam longint TWO_PI        = 64'sd3373259426;
    localparam longint PI            = 64'sd1686629713;
    localparam longint HALF_PI       = 64'sd843314856;
    localparam longint THREE_HALF_PI = 64'sd2529944570;
    localparam longint GAIN_Q30      = 64'sd652032874;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct packed {
        logic [31:0] dx;
        logic [31:0] dy;
        logic        sat;
    } t_xy;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_s_tvalid;
    logic                       o_s_tready;
    logic [31:0]                i_s_tdata;    // [31:0] input_increment
    logic                       o_m_tvalid;
    logic                       i_m_tready;
    logic [63:0]                o_m_tdata;    // [31:0] delta_x, [63:32] delta_y
    logic                       o_m_tuser;    // [0] saturated
    logic                       i_cfg_we;
    logic [cig_pkg::W_ADDR-1:0] i_cfg_addr;
    logic [cig_pkg::W_CFG-1:0]  i_cfg_wdata;

    logic [31:0] cfg_radius;
    logic [31:0] cfg_rate;
    logic [31:0] cfg_period;
    logic        cfg_free_run;
    logic [31:0] phase_acc;

    longint arc_tab [0:29] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2
    };

    logic [31:0] pend_q [$];
    t_xy         incr_q [$];

    t_idle_mode idle_mode;
    bit         s_took;
    int         err_cnt;
    int         item_cnt;
    int         result_cnt;
    int         sat_cnt;
    int         cfg_cnt;

    circle_increment_generator #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("timeout: %0d items, %0d results, %0d still expected",
                 item_cnt, result_cnt, incr_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // scale a Q3.29 increment by the radius, round away from zero, clamp
    function automatic longint scale_clamp(input longint t, inout bit sat);
        longint unsigned mag;
        longint unsigned r;
        mag = (t < 0) ? -t : t;
        r = (64'(cfg_radius) * 64'(mag[31:0]) + 64'h1000_0000) >> 29;
        if (mag > 64'hFFFF_FFFF)
            r = 64'd1 << 40;
        if (t < 0) begin
            if (r > 64'h8000_0000) begin
                sat = 1'b1;
                return -64'sd2147483648;
            end
            return -longint'(r);
        end
        if (r > 64'h7FFF_FFFF) begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        return longint'(r);
    endfunction

    function automatic t_xy circle_step(input logic [31:0] incr);
        longint rate, per, inc, step, p, a, x, y, z, nx;
        bit     neg;
        bit     sat;
        t_xy    res;
        sat  = 1'b0;
        rate = $signed(cfg_rate);
        per  = cfg_period;
        inc  = $signed(incr);
        if (cfg_free_run)
            step = (rate * per + 64'sd67108864) >>> 27;
        else
            step = (rate * inc + 64'sd1024) >>> 11;
        if (step > TWO_PI - 1) begin
            step = TWO_PI - 1;
            sat  = 1'b1;
        end
        if (step < -(TWO_PI - 1)) begin
            step = -(TWO_PI - 1);
            sat  = 1'b1;
        end

        p = longint'(phase_acc) + step;
        if (p >= TWO_PI)
            p = p - TWO_PI;
        else if (p < 0)
            p = p + TWO_PI;
        phase_acc = p[31:0];

        if (p < HALF_PI) begin
            a   = p;
            neg = 1'b0;
        end else if (p < THREE_HALF_PI) begin
            a   = p - PI;
            neg = 1'b1;
        end else begin
            a   = p - TWO_PI;
            neg = 1'b0;
        end

        x = GAIN_Q30;
        y = 0;
        z = a * 2;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - arc_tab[i];
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + arc_tab[i];
            end
            x = nx;
        end
        if (neg) begin
            x = -x;
            y = -y;
        end

        x = scale_clamp((step * x + 64'sd536870912) >>> 30, sat);
        y = scale_clamp((step * y + 64'sd536870912) >>> 30, sat);
        res.dx  = x[31:0];
        res.dy  = y[31:0];
        res.sat = sat;
        return res;
    endfunction

    function automatic bit sender_holds();
        case (idle_mode)
            IDLE_SEND: return $urandom_range(0, 99) < 62;
            IDLE_BOTH: return $urandom_range(0, 99) < 6;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (idle_mode)
            IDLE_RECV: return $urandom_range(0, 99) < 62;
            IDLE_BOTH: return $urandom_range(0, 99) < 6;
            default:   return 1'b0;
        endcase
    endfunction

    always @(negedge i_clk) begin
        if (i_rst_n && (!i_s_tvalid || s_took)) begin
            if (pend_q.size() != 0 && !sender_holds()) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= pend_q.pop_front();
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
        i_m_tready <= !receiver_stalls();
    end

    always @(posedge i_clk) begin
        t_xy want;
        s_took = i_rst_n && i_s_tvalid && o_s_tready;
        if (s_took) begin
            incr_q.push_back(circle_step(i_s_tdata));
            item_cnt++;
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            result_cnt++;
            if (o_m_tuser)
                sat_cnt++;
            if (incr_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("%t: result with none expected: dx=%h dy=%h sat=%b",
                             $realtime, o_m_tdata[31:0], o_m_tdata[63:32], o_m_tuser);
            end else begin
                want = incr_q.pop_front();
                if (o_m_tdata[31:0] !== want.dx || o_m_tdata[63:32] !== want.dy ||
                    o_m_tuser !== want.sat) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display({"%t: result %0d: expected dx=%h dy=%h sat=%b,",
                                  " got dx=%h dy=%h sat=%b"},
                                 $realtime, result_cnt, want.dx, want.dy, want.sat,
                                 o_m_tdata[31:0], o_m_tdata[63:32], o_m_tuser);
                end
            end
        end
    end

    // wait for the block to go idle, then allow the pipeline to empty
    task automatic settle();
        while (pend_q.size() != 0 || i_s_tvalid || incr_q.size() != 0)
            @(posedge i_clk);
        repeat (CORDIC_STAGES + 16) @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [31:0] radius, input logic [31:0] rate,
                            input logic [31:0] period, input logic [31:0] free_run);
        logic [31:0] vals [4];
        vals[cig_pkg::REG_RADIUS]   = radius;
        vals[cig_pkg::REG_RATE]     = rate;
        vals[cig_pkg::REG_PERIOD]   = period;
        vals[cig_pkg::REG_FREE_RUN] = free_run;
        settle();
        for (int k = 0; k < 4; k++) begin
            @(negedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= k[cig_pkg::W_ADDR-1:0];
            i_cfg_wdata <= vals[k];
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_cfg_we     <= 1'b0;
        cfg_radius   = radius;
        cfg_rate     = rate;
        cfg_period   = period;
        cfg_free_run = free_run[0];
        cfg_cnt++;
    endtask

    initial begin
        logic signed [31:0] sv;
        logic [31:0]        rad, rate, per, fr;

        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_m_tready   = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_addr   = '0;
        i_cfg_wdata  = '0;
        cfg_radius   = '0;
        cfg_rate     = '0;
        cfg_period   = '0;
        cfg_free_run = 1'b0;
        phase_acc    = '0;
        idle_mode    = IDLE_NONE;
        s_took       = 1'b0;
        err_cnt      = 0;
        item_cnt     = 0;
        result_cnt   = 0;
        sat_cnt      = 0;
        cfg_cnt      = 0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: all zero, outputs zero
        pend_q = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000};

        // zero radius with a live rate
        set_regs(32'h0, 32'h0100_0000, 32'h0, 32'h0);
        pend_q.push_back(32'h0001_0000);

        // unit radius and rate: zero, small, wraps both ways, step clamps
        set_regs(32'h0001_0000, 32'h0100_0000, 32'h0, 32'h0);
        pend_q = '{32'h0000_0000, 32'h0001_0000, 32'hFFFF_0000,
                   32'h0003_0000, 32'h0003_0000, 32'hFFFD_0000, 32'hFFFD_0000,
                   32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF};

        // widest radius and rate: output clamps
        set_regs(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0);
        pend_q = '{32'h0001_0000, 32'hFFFF_0000};

        // zero rate: phase holds
        set_regs(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0);
        pend_q.push_back(32'h1234_5678);

        // free run, most negative rate and longest period
        set_regs(32'h0001_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        pend_q = '{32'h7FFF_FFFF, 32'h0000_0000};

        // free run, moderate step
        set_regs(32'h0004_0000, 32'h0001_0000, 32'h0100_0000, 32'h0000_0001);
        pend_q = '{32'h8000_0000, 32'h5555_AAAA};

        for (int r = 0; r < 12; r++) begin
            if (r == 0) begin
                rad  = 32'hFFFF_FFFF;
                rate = 32'h8000_0000;
                per  = 32'hFFFF_FFFF;
                fr   = 32'h0;
            end else if (r == 1) begin
                rad  = 32'h1;
                rate = 32'h1;
                per  = 32'h1;
                fr   = 32'hFFFF_FFFF;
            end else begin
                rad  = $urandom >> $urandom_range(0, 31);
                sv   = $urandom;
                rate = sv >>> $urandom_range(0, 31);
                per  = $urandom >> $urandom_range(0, 31);
                fr   = ($urandom_range(0, 3) == 0) ? $urandom : ($urandom & 32'hFFFF_FFFE);
            end
            set_regs(rad, rate, per, fr);
            idle_mode = t_idle_mode'(r % 4);
            for (int k = 0; k < 152; k++) begin
                sv = $urandom;
                sv = sv >>> $urandom_range(0, 31);
                if ($urandom_range(0, 19) == 0)
                    sv = '0;
                pend_q.push_back(sv);
            end
        end

        settle();
        repeat (50) @(posedge i_clk);
        $display("%0d items over %0d register settings, %0d results checked, %0d saturated",
                 item_cnt, cfg_cnt, result_cnt, sat_cnt);
        $display("idling phases: none, sender, receiver, both; %0d mismatches", err_cnt);
        if (err_cnt == 0 && incr_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
